// File: hw/rtl/rau_pkg.sv
// Shared action codes and controller/datapath command and status types.
package rau_pkg;

   localparam int ACTION_WIDTH = 4;
   localparam int RESULT_WIDTH = 32;

   localparam logic [ACTION_WIDTH-1:0] ACT_ADD  = 4'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_SUB  = 4'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_MUL  = 4'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_DIV  = 4'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_EQ   = 4'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_GT   = 4'd5;
   localparam logic [ACTION_WIDTH-1:0] ACT_GE   = 4'd6;
   localparam logic [ACTION_WIDTH-1:0] ACT_LT   = 4'd7;
   localparam logic [ACTION_WIDTH-1:0] ACT_LE   = 4'd8;
   localparam logic [ACTION_WIDTH-1:0] ACT_NORM = 4'd9;

   // Product selected for the shared multiplier
   localparam logic [1:0] MUL_AN_BD = 2'd0;
   localparam logic [1:0] MUL_AD_BN = 2'd1;
   localparam logic [1:0] MUL_AN_BN = 2'd2;
   localparam logic [1:0] MUL_AD_BD = 2'd3;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       finish;
   } rau_cmd_type;

   typedef struct packed {
      logic gcd_done;
   } rau_status_type;

endpackage

// File: hw/rtl/rau_if.sv
// Request and response channel interfaces.
interface rau_req_if import rau_pkg::*; #(
   parameter int OPERAND_WIDTH = 16
);
   logic                            valid;
   logic                            ready;
   logic [ACTION_WIDTH-1:0]         action;
   logic signed [OPERAND_WIDTH-1:0] a_num;
   logic signed [OPERAND_WIDTH-1:0] a_den;
   logic signed [OPERAND_WIDTH-1:0] b_num;
   logic signed [OPERAND_WIDTH-1:0] b_den;

   modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic signed [RESULT_WIDTH-1:0] res_num;
   logic signed [RESULT_WIDTH-1:0] res_den;
   logic                           cmp_true;
   logic                           zero_den;

   modport source (output valid, res_num, res_den, cmp_true, zero_den, input ready);
   modport sink   (input valid, res_num, res_den, cmp_true, zero_den, output ready);
endinterface

// File: hw/rtl/rau_ctrl.sv
// Sequencer for multiply, GCD and divide phases, and response valid.
module rau_ctrl import rau_pkg::*; #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [ACTION_WIDTH-1:0] req_action,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  rau_status_type          status,
   output rau_cmd_type             cmd
);

   localparam int CW = $clog2(OPERAND_WIDTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_GCD  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = (req_action == ACT_NORM) ? ST_GCD : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = cnt_ff[1:0];
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CW'(3)) state_in = ST_DONE;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(OPERAND_WIDTH - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/rau_datapath.sv
// Operand registers, shared multiplier, binary GCD, dual divider, result register.
module rau_datapath import rau_pkg::*; #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                            clock,
   input  rau_cmd_type                     cmd,
   output rau_status_type                  status,
   input  logic [ACTION_WIDTH-1:0]         req_action,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0] req_b_den,
   output logic signed [RESULT_WIDTH-1:0]  rsp_res_num,
   output logic signed [RESULT_WIDTH-1:0]  rsp_res_den,
   output logic                            rsp_cmp_true,
   output logic                            rsp_zero_den
);

   localparam int W  = OPERAND_WIDTH;
   localparam int KW = $clog2(OPERAND_WIDTH);

   logic [ACTION_WIDTH-1:0] action_ff;
   logic signed [W-1:0]     an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [2*W-1:0]   lhs_ff, rhs_ff, nn_ff, dd_ff;
   logic [W-1:0]            x_ff, y_ff, g_ff;
   logic [KW-1:0]           k_ff;
   logic                    g_zero_ff;
   logic [W-1:0]            rem_a_ff, quo_a_ff, rem_d_ff, quo_d_ff;

   logic signed [W-1:0]     mul_a, mul_b;
   logic signed [2*W-1:0]   product;
   logic [W-1:0]            gcd_val;
   logic [W:0]              sh_a, sh_d, sub_a, sub_d;

   logic signed [RESULT_WIDTH-1:0] res_num_in, res_den_in;
   logic                           cmp_in, zd_in;
   logic [RESULT_WIDTH-1:0]        qa32;
   logic                           eq_den;

   // Shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MUL_AN_BD: begin mul_a = an_ff; mul_b = bd_ff; end
         MUL_AD_BN: begin mul_a = ad_ff; mul_b = bn_ff; end
         MUL_AN_BN: begin mul_a = an_ff; mul_b = bn_ff; end
         default:   begin mul_a = ad_ff; mul_b = bd_ff; end
      endcase
   end
   assign product = mul_a * mul_b;

   assign status.gcd_done = (x_ff == '0) || (y_ff == '0);
   assign gcd_val         = (x_ff | y_ff) << k_ff;

   // Restoring divide steps for both magnitudes against the same divisor
   assign sh_a  = {rem_a_ff, quo_a_ff[W-1]};
   assign sh_d  = {rem_d_ff, quo_d_ff[W-1]};
   assign sub_a = sh_a - {1'b0, g_ff};
   assign sub_d = sh_d - {1'b0, g_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         an_ff     <= req_a_num;
         ad_ff     <= req_a_den;
         bn_ff     <= req_b_num;
         bd_ff     <= req_b_den;
         x_ff      <= req_a_num[W-1] ? W'(-req_a_num) : W'(req_a_num);
         y_ff      <= req_a_den[W-1] ? W'(-req_a_den) : W'(req_a_den);
         k_ff      <= '0;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_AN_BD: lhs_ff <= product;
            MUL_AD_BN: rhs_ff <= product;
            MUL_AN_BN: nn_ff  <= product;
            default:   dd_ff  <= product;
         endcase
      end
      if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= (x_ff - y_ff) >> 1;
         end else begin
            y_ff <= (y_ff - x_ff) >> 1;
         end
      end
      if (cmd.div_init) begin
         g_ff      <= gcd_val;
         g_zero_ff <= (gcd_val == '0);
         rem_a_ff  <= '0;
         rem_d_ff  <= '0;
         quo_a_ff  <= an_ff[W-1] ? W'(-an_ff) : W'(an_ff);
         quo_d_ff  <= ad_ff[W-1] ? W'(-ad_ff) : W'(ad_ff);
      end
      if (cmd.div_step) begin
         rem_a_ff <= sub_a[W] ? sh_a[W-1:0] : sub_a[W-1:0];
         rem_d_ff <= sub_d[W] ? sh_d[W-1:0] : sub_d[W-1:0];
         quo_a_ff <= {quo_a_ff[W-2:0], ~sub_a[W]};
         quo_d_ff <= {quo_d_ff[W-2:0], ~sub_d[W]};
      end
      if (cmd.finish) begin
         rsp_res_num  <= res_num_in;
         rsp_res_den  <= res_den_in;
         rsp_cmp_true <= cmp_in;
         rsp_zero_den <= zd_in;
      end
   end

   assign eq_den = (ad_ff == bd_ff);
   assign qa32   = RESULT_WIDTH'(quo_a_ff);

   always_comb begin
      res_num_in = '0;
      res_den_in = '0;
      cmp_in     = 1'b0;
      zd_in      = 1'b0;
      case (action_ff) inside
         ACT_ADD, ACT_SUB: begin
            if (eq_den) begin
               res_num_in = (action_ff == ACT_ADD)
                  ? RESULT_WIDTH'(an_ff) + RESULT_WIDTH'(bn_ff)
                  : RESULT_WIDTH'(an_ff) - RESULT_WIDTH'(bn_ff);
               res_den_in = RESULT_WIDTH'(ad_ff);
            end else begin
               res_num_in = (action_ff == ACT_ADD)
                  ? RESULT_WIDTH'(lhs_ff) + RESULT_WIDTH'(rhs_ff)
                  : RESULT_WIDTH'(lhs_ff) - RESULT_WIDTH'(rhs_ff);
               res_den_in = RESULT_WIDTH'(dd_ff);
            end
            zd_in = (res_den_in == '0);
         end
         ACT_MUL: begin
            res_num_in = RESULT_WIDTH'(nn_ff);
            res_den_in = RESULT_WIDTH'(dd_ff);
            zd_in      = (res_den_in == '0);
         end
         ACT_DIV: begin
            res_num_in = RESULT_WIDTH'(lhs_ff);
            res_den_in = RESULT_WIDTH'(rhs_ff);
            zd_in      = (res_den_in == '0);
         end
         ACT_EQ: cmp_in = (lhs_ff == rhs_ff);
         ACT_GT: cmp_in = (lhs_ff >  rhs_ff);
         ACT_GE: cmp_in = (lhs_ff >= rhs_ff);
         ACT_LT: cmp_in = (lhs_ff <  rhs_ff);
         ACT_LE: cmp_in = (lhs_ff <= rhs_ff);
         ACT_NORM: begin
            // both zero: result stays 0/0
            if (!g_zero_ff) begin
               // flip the numerator sign along with a negative denominator
               res_num_in = (an_ff[W-1] ^ ad_ff[W-1]) ? -qa32 : qa32;
               res_den_in = RESULT_WIDTH'(quo_d_ff);
            end
            zd_in = (res_den_in == '0);
         end
         default: ;
      endcase
   end

endmodule

// File: hw/rtl/rational_arith_unit.sv
// Top level: signed fraction arithmetic, compare and normalize unit.
//
//   Channel   Role     Beat contents
//   req_ch    sink     action, a_num, a_den, b_num, b_den
//   rsp_ch    source   res_num, res_den, cmp_true, zero_den
//
// Add, sub, mul, div and the compares go from request beat to response
// through accept, four passes through the one shared multiplier, finish.
// Normalize runs a binary GCD (one shift or subtract-and-shift per cycle,
// at most 2*OPERAND_WIDTH-2 steps) and then an OPERAND_WIDTH-step restoring
// divide of both magnitudes by the GCD.
// Reset clears the sequencer and response valid only. A stalled response
// holds in its register; the next request is taken while it waits.
module rational_arith_unit import rau_pkg::*; #(
   parameter int OPERAND_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);

   rau_cmd_type    cmd;
   rau_status_type status;

   // Sequencer: owns request ready and response valid
   rau_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: captures the request beat, drives the response payload
   rau_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .req_action   (req_ch.action),
      .req_a_num    (req_ch.a_num),
      .req_a_den    (req_ch.a_den),
      .req_b_num    (req_ch.b_num),
      .req_b_den    (req_ch.b_den),
      .rsp_res_num  (rsp_ch.res_num),
      .rsp_res_den  (rsp_ch.res_den),
      .rsp_cmp_true (rsp_ch.cmp_true),
      .rsp_zero_den (rsp_ch.zero_den)
   );

endmodule
